### sv/uqsd_pkg.sv
// Shared types, codes and helpers for the URL query splitter/decoder.
// Used by uqsd_front, uqsd_queue, uqsd_back and url_query_splitter_decoder.
package uqsd_pkg;

    localparam int QDEPTH_DEF = 4;

    localparam logic [7:0] CH_QUERY   = 8'h3F;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_PCT     = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UZ      = 8'h5A;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LZ      = 8'h7A;
    localparam logic [5:0] LETTER_BASE = 6'd10;

    localparam logic [1:0] PART_PATH  = 2'd0;
    localparam logic [1:0] PART_KEY   = 2'd1;
    localparam logic [1:0] PART_VALUE = 2'd2;
    localparam logic [1:0] PART_NONE  = 2'd3;

    localparam logic [2:0] EV_BYTE    = 3'd0;
    localparam logic [2:0] EV_KEPT    = 3'd1;
    localparam logic [2:0] EV_DROPPED = 3'd2;
    localparam logic [2:0] EV_BAD     = 3'd3;
    localparam logic [2:0] EV_END     = 3'd4;

    // One command per transfer: up to three results, emitted slot 0, 1, 2.
    typedef struct packed {
        logic       byte_v;   // slot 0: data byte or bad escape
        logic       is_bad;
        logic [7:0] data;
        logic [1:0] part;
        logic       pair_v;   // slot 1: pair closed
        logic       kept;
        logic       end_v;    // slot 2: end of target
    } t_cmd;

    // {ok, value}: 0-9 -> 0..9, A-Z and a-z -> 10..35
    function automatic logic [6:0] digit_of(input logic [7:0] b);
        logic [7:0] d;
        d = 8'd0;
        if (b >= CH_0 && b <= CH_9) begin
            d = b - CH_0;
            return {1'b1, d[5:0]};
        end else if (b >= CH_UA && b <= CH_UZ) begin
            d = b - CH_UA;
            return {1'b1, d[5:0] + LETTER_BASE};
        end else if (b >= CH_LA && b <= CH_LZ) begin
            d = b - CH_LA;
            return {1'b1, d[5:0] + LETTER_BASE};
        end
        return 7'd0;
    endfunction

endpackage

### sv/uqsd_front.sv
// Front end: accepts target bytes, tracks path/key/value and escape state,
// and builds at most one result command per byte. Depends on uqsd_pkg.
module uqsd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_target_byte,
    input  logic            i_is_last,
    output logic            o_push,
    output uqsd_pkg::t_cmd  o_cmd
);
    import uqsd_pkg::*;

    typedef enum logic [3:0] {
        PH_PATH      = 4'b0001,
        PH_KEY_EMPTY = 4'b0010,
        PH_VALUE     = 4'b0100,
        PH_KEY_BYTES = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        ESC_NONE = 3'b001,
        ESC_HIGH = 3'b010,
        ESC_LOW  = 3'b100
    } t_esc;

    t_phase     r_phase, n_phase;
    t_esc       r_esc, n_esc;
    logic [5:0] r_high, n_high;
    logic       r_err, n_err;

    t_cmd       cmd;
    logic       bad;
    logic [6:0] dig;
    logic [7:0] esc_byte;

    function automatic logic [1:0] part_of(input t_phase ph);
        unique case (ph)
            PH_PATH:  return PART_PATH;
            PH_VALUE: return PART_VALUE;
            default:  return PART_KEY;
        endcase
    endfunction

    assign dig      = digit_of(i_target_byte);
    assign esc_byte = {r_high[3:0], 4'b0000} + {2'b00, dig[5:0]};

    always_comb begin
        n_phase = r_phase;
        n_esc   = r_esc;
        n_high  = r_high;
        n_err   = r_err;
        bad     = 1'b0;
        cmd     = '0;
        cmd.part  = PART_NONE;
        cmd.end_v = i_is_last;

        if (!r_err) begin
            if (r_phase == PH_PATH) begin
                if (i_target_byte == CH_QUERY) begin
                    n_phase = PH_KEY_EMPTY;
                end else begin
                    cmd.byte_v = 1'b1;
                    cmd.data   = i_target_byte;
                    cmd.part   = PART_PATH;
                end
            end else if (r_esc != ESC_NONE) begin
                if (!dig[6]) begin
                    bad = 1'b1;
                end else if (r_esc == ESC_HIGH) begin
                    if (i_is_last) begin
                        bad = 1'b1;
                    end else begin
                        n_high = dig[5:0];
                        n_esc  = ESC_LOW;
                    end
                end else begin
                    cmd.byte_v = 1'b1;
                    cmd.data   = esc_byte;
                    cmd.part   = part_of(r_phase);
                    n_esc      = ESC_NONE;
                    n_high     = 6'd0;
                end
            end else if (i_target_byte == CH_AMP) begin
                cmd.pair_v = (r_phase == PH_VALUE) || (r_phase == PH_KEY_BYTES);
                cmd.kept   = (r_phase == PH_VALUE);
                n_phase    = PH_KEY_EMPTY;
            end else if (i_target_byte == CH_EQ && r_phase != PH_VALUE) begin
                n_phase = PH_VALUE;
            end else if (i_target_byte == CH_PCT) begin
                if (r_phase == PH_KEY_EMPTY) n_phase = PH_KEY_BYTES;
                if (i_is_last) begin
                    bad = 1'b1;
                end else begin
                    n_esc = ESC_HIGH;
                end
            end else begin
                if (r_phase == PH_KEY_EMPTY) n_phase = PH_KEY_BYTES;
                cmd.byte_v = 1'b1;
                cmd.data   = (i_target_byte == CH_PLUS) ? CH_SPACE : i_target_byte;
                cmd.part   = part_of(n_phase);
            end

            if (bad) begin
                cmd.byte_v = 1'b1;
                cmd.is_bad = 1'b1;
                cmd.data   = 8'd0;
                cmd.part   = PART_NONE;
                n_err      = 1'b1;
                n_esc      = ESC_NONE;
                n_high     = 6'd0;
            end
        end

        if (i_is_last) begin
            if (!n_err && (n_phase == PH_VALUE || n_phase == PH_KEY_BYTES)) begin
                cmd.pair_v = 1'b1;
                cmd.kept   = (n_phase == PH_VALUE);
            end
            n_phase = PH_PATH;
            n_esc   = ESC_NONE;
            n_high  = 6'd0;
            n_err   = 1'b0;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = i_accept && (cmd.byte_v || cmd.pair_v || cmd.end_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PATH;
            r_esc   <= ESC_NONE;
            r_high  <= 6'd0;
            r_err   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_high  <= n_high;
            r_err   <= n_err;
        end
    end

`ifndef SYNTH
    a_err_no_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> (r_esc == ESC_NONE && r_high == 6'd0))
        else $error("escape pending while in error");
    a_path_no_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PATH) |-> (r_esc == ESC_NONE))
        else $error("escape pending in path phase");
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_is_last) |=> (r_phase == PH_PATH && !r_err))
        else $error("state not cleared after end of target");
`endif

endmodule

### sv/uqsd_queue.sv
// Short command queue between front and back end.
// Depends on uqsd_pkg for the command type.
module uqsd_queue #(
    parameter int DEPTH = uqsd_pkg::QDEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  uqsd_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output uqsd_pkg::t_cmd  o_head,
    output logic            o_empty,
    output logic            o_full
);
    import uqsd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push, pop;

    assign o_empty = (r_cnt == CNT_W'(0));
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign push    = i_push && !o_full;
    assign pop     = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            if (pop)  r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            if (push && !pop)      r_cnt <= r_cnt + CNT_W'(1);
            else if (pop && !push) r_cnt <= r_cnt - CNT_W'(1);
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

### sv/uqsd_back.sv
// Back end: serializes each queued command into result transfers through
// a registered output stage. Depends on uqsd_pkg.
module uqsd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  uqsd_pkg::t_cmd  i_head,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_data_byte,
    output logic [1:0]      o_part,
    output logic [2:0]      o_event_res,
    output logic            o_final_res
);
    import uqsd_pkg::*;

    logic [2:0] r_done;
    logic       r_valid;
    logic [7:0] r_data;
    logic [1:0] r_part;
    logic [2:0] r_ev;
    logic       r_final;

    logic [2:0] hv, pend, sel, rest;
    logic       load, last_one;
    logic [7:0] s_data;
    logic [1:0] s_part;
    logic [2:0] s_ev;

    assign hv   = {i_head.end_v, i_head.pair_v, i_head.byte_v};
    assign pend = hv & ~r_done;
    assign sel  = pend[0] ? 3'b001 : (pend[1] ? 3'b010 : 3'b100);
    assign rest = pend & ~sel;
    assign last_one = (rest == 3'b000);
    assign load = !i_empty && (!r_valid || !i_stall);
    assign o_pop = load && last_one;

    always_comb begin
        s_data = 8'd0;
        s_part = PART_NONE;
        s_ev   = EV_END;
        if (sel[0]) begin
            if (i_head.is_bad) begin
                s_ev = EV_BAD;
            end else begin
                s_ev   = EV_BYTE;
                s_data = i_head.data;
                s_part = i_head.part;
            end
        end else if (sel[1]) begin
            s_ev = i_head.kept ? EV_KEPT : EV_DROPPED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= 3'b000;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_done  <= last_one ? 3'b000 : (r_done | sel);
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data  <= s_data;
            r_part  <= s_part;
            r_ev    <= s_ev;
            r_final <= last_one;
        end
    end

    assign o_valid     = r_valid;
    assign o_data_byte = r_data;
    assign o_part      = r_part;
    assign o_event_res = r_ev;
    assign o_final_res = r_final;

`ifndef SYNTH
    a_end_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_ev == EV_END) |-> r_final)
        else $error("end of target not marked final");
    a_done_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> ((r_done & ~hv) == 3'b000))
        else $error("done mask outside command");
    a_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (pend != 3'b000))
        else $error("queued command with nothing to send");
`endif

endmodule

### sv/url_query_splitter_decoder.sv
// Request target splitter and query decoder. One target byte is taken per
// clock while the command queue (QDEPTH entries) has room; results leave one
// per clock while the output is not stalled, through a registered output; a
// result passes through a queue entry and then the output register. A byte
// gives up to three results (data or bad escape, pair event, end), and the
// single output port sets the sustained rate. Depends on uqsd_pkg.
module url_query_splitter_decoder #(
    parameter int QDEPTH = uqsd_pkg::QDEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_target_byte,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_data_byte,
    output logic [1:0] o_part,
    output logic [2:0] o_event_res,
    output logic       o_final_res
);
    import uqsd_pkg::*;

    t_cmd front_cmd, head_cmd;
    logic push, pop, q_empty, q_full, accept;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    uqsd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_target_byte (i_target_byte),
        .i_is_last     (i_is_last),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    uqsd_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    uqsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_cmd),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data_byte (o_data_byte),
        .o_part      (o_part),
        .o_event_res (o_event_res),
        .o_final_res (o_final_res)
    );

endmodule

### sim/url_query_splitter_decoder_test.sv
`timescale 1ns / 100ps
// Testbench for url_query_splitter_decoder: directed request targets, then random
// targets, checked against a behavioral query decoder. Depends on uqsd_pkg and the RTL.
module url_query_splitter_decoder_test;
    import uqsd_pkg::*;

    typedef enum logic [1:0] {PH_PATH, PH_KEY_EMPTY, PH_VALUE, PH_KEY_BYTES} phase_e;
    typedef enum logic [1:0] {ESC_NONE, ESC_HIGH, ESC_LOW} esc_e;
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] part;
        logic [2:0] ev;
        logic       fin;
    } result_t;

    typedef struct packed {
        logic [7:0]    tb;
        logic          last;
        logic          pause;
        logic          known;
        logic [1:0]    n_known;
        result_t [2:0] want;
    } stim_t;

    localparam int DIR_ROWS    = 26;
    localparam int RAND_ITEMS  = 444;
    localparam int TAIL_CYCLES = 16;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_target_byte = '0;
    logic       i_is_last = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_data_byte;
    logic [1:0] o_part;
    logic [2:0] o_event_res;
    logic       o_final_res;

    phase_e     dec_phase = PH_PATH;
    esc_e       dec_esc = ESC_NONE;
    int         dec_high = 0;
    logic       dec_err = 1'b0;

    result_t    step_results[$];
    result_t    expected_results[$];
    stim_t      stim_q[$];
    logic [7:0] target_bytes[$];
    int         stim_idx = 0;
    int         errors = 0;

    url_query_splitter_decoder u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_target_byte(i_target_byte),
        .i_is_last    (i_is_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data_byte  (o_data_byte),
        .o_part       (o_part),
        .o_event_res  (o_event_res),
        .o_final_res  (o_final_res)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic result_t mk_result(input logic [7:0] data, input logic [1:0] part,
                                          input logic [2:0] ev, input logic fin);
        result_t r;
        r.data = data;
        r.part = part;
        r.ev   = ev;
        r.fin  = fin;
        return r;
    endfunction

    function automatic void emit(input logic [7:0] data, input logic [1:0] part,
                                 input logic [2:0] ev);
        step_results.push_back(mk_result(data, part, ev, 1'b0));
    endfunction

    // -1 when b is not an escape digit
    function automatic int digit_val(input logic [7:0] b);
        if (b >= CH_0 && b <= CH_9) return int'(b - CH_0);
        if (b >= CH_UA && b <= CH_UZ) return int'(b - CH_UA) + 10;
        if (b >= CH_LA && b <= CH_LZ) return int'(b - CH_LA) + 10;
        return -1;
    endfunction

    function automatic logic [1:0] part_now();
        case (dec_phase)
            PH_PATH:  return PART_PATH;
            PH_VALUE: return PART_VALUE;
            default:  return PART_KEY;
        endcase
    endfunction

    function automatic void close_pair();
        if (dec_phase == PH_VALUE) emit(8'h00, PART_NONE, EV_KEPT);
        else if (dec_phase == PH_KEY_BYTES) emit(8'h00, PART_NONE, EV_DROPPED);
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic last);
        int      v;
        logic    bad;
        result_t tail;
        bad = 1'b0;
        step_results.delete();
        if (!dec_err) begin
            if (dec_phase == PH_PATH) begin
                if (b == CH_QUERY) dec_phase = PH_KEY_EMPTY;
                else emit(b, PART_PATH, EV_BYTE);
            end else if (dec_esc != ESC_NONE) begin
                v = digit_val(b);
                if (v < 0 || (dec_esc == ESC_HIGH && last)) begin
                    bad = 1'b1;
                end else if (dec_esc == ESC_HIGH) begin
                    dec_high = v;
                    dec_esc = ESC_LOW;
                end else begin
                    emit(8'((dec_high * 16 + v) % 256), part_now(), EV_BYTE);
                    dec_esc = ESC_NONE;
                    dec_high = 0;
                end
            end else if (b == CH_AMP) begin
                close_pair();
                dec_phase = PH_KEY_EMPTY;
            end else if (b == CH_EQ && dec_phase != PH_VALUE) begin
                dec_phase = PH_VALUE;
            end else begin
                if (dec_phase == PH_KEY_EMPTY) dec_phase = PH_KEY_BYTES;
                if (b == CH_PCT) begin
                    if (last) bad = 1'b1;
                    else dec_esc = ESC_HIGH;
                end else begin
                    emit(b == CH_PLUS ? CH_SPACE : b, part_now(), EV_BYTE);
                end
            end
            if (bad) begin
                emit(8'h00, PART_NONE, EV_BAD);
                dec_err = 1'b1;
                dec_esc = ESC_NONE;
                dec_high = 0;
            end
        end
        if (last) begin
            if (!dec_err) close_pair();
            emit(8'h00, PART_NONE, EV_END);
            dec_phase = PH_PATH;
            dec_esc = ESC_NONE;
            dec_high = 0;
            dec_err = 1'b0;
        end
        if (step_results.size() != 0) begin
            tail = step_results.pop_back();
            tail.fin = 1'b1;
            step_results.push_back(tail);
        end
    endfunction

    function automatic stim_t plain(input logic [7:0] b, input logic last, input logic pause);
        stim_t s;
        s = '0;
        s.tb = b;
        s.last = last;
        s.pause = pause;
        return s;
    endfunction

    function automatic stim_t known_row(input logic [7:0] b, input logic last, input int n,
                                        input result_t e0, input result_t e1,
                                        input result_t e2);
        stim_t s;
        s = plain(b, last, 1'b0);
        s.known = 1'b1;
        s.n_known = 2'(n);
        s.want[0] = e0;
        s.want[1] = e1;
        s.want[2] = e2;
        return s;
    endfunction

    function automatic logic [7:0] digit_char();
        int r;
        r = $urandom_range(61);
        if (r < 10) return CH_0 + 8'(r);
        if (r < 36) return CH_UA + 8'(r - 10);
        return CH_LA + 8'(r - 36);
    endfunction

    function automatic void add_text(input int max_len);
        int kind;
        repeat ($urandom_range(max_len)) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                target_bytes.push_back(digit_char());
            end else if (kind < 55) begin
                target_bytes.push_back(CH_PLUS);
            end else if (kind < 75) begin
                target_bytes.push_back(CH_PCT);
                target_bytes.push_back($urandom_range(15) == 0 ? 8'($urandom) : digit_char());
                target_bytes.push_back($urandom_range(15) == 0 ? 8'($urandom) : digit_char());
            end else begin
                target_bytes.push_back(8'($urandom));
            end
        end
    endfunction

    // mostly well-formed targets; about one in ten is raw noise
    function automatic void gen_target(input logic pause);
        int         pairs;
        logic [7:0] pb;
        target_bytes.delete();
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 8)) target_bytes.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(3)) begin
                pb = 8'($urandom);
                if (pb == CH_QUERY) pb = CH_PLUS;
                target_bytes.push_back(pb);
            end
            if ($urandom_range(9) != 0) begin
                target_bytes.push_back(CH_QUERY);
                pairs = $urandom_range(4);
                for (int p = 0; p < pairs; p++) begin
                    if (p != 0) target_bytes.push_back(CH_AMP);
                    add_text(3);
                    if ($urandom_range(3) != 0) begin
                        target_bytes.push_back(CH_EQ);
                        add_text(4);
                    end
                end
                if ($urandom_range(7) == 0) target_bytes.push_back(CH_AMP);
            end
        end
        if (target_bytes.size() == 0) target_bytes.push_back(8'($urandom));
        foreach (target_bytes[i]) begin
            stim_q.push_back(plain(target_bytes[i], i == target_bytes.size() - 1,
                                   pause && i == 0));
        end
    endfunction

    always @(posedge i_clk) begin
        stim_t      item;
        result_t    want;
        logic       take;
        idle_mode_e mode;
        int         gap_pct;
        int         stall_pct;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: data_byte %0h part %0d event_res %0d",
                           o_data_byte, o_part, o_event_res);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_data_byte !== want.data) begin
                        $error("data_byte: expected %0h, actual %0h", want.data, o_data_byte);
                        errors++;
                    end
                    if (o_part !== want.part) begin
                        $error("part: expected %0d, actual %0d", want.part, o_part);
                        errors++;
                    end
                    if (o_event_res !== want.ev) begin
                        $error("event_res: expected %0d, actual %0d", want.ev, o_event_res);
                        errors++;
                    end
                    if (o_final_res !== want.fin) begin
                        $error("final_res: expected %0d, actual %0d", want.fin, o_final_res);
                        errors++;
                    end
                end
            end

            take = i_valid && !o_stall;
            if (take) begin
                item = stim_q[stim_idx];
                decode_byte(item.tb, item.last);
                if (item.known) begin
                    for (int k = 0; k < item.n_known; k++)
                        expected_results.push_back(item.want[k]);
                end else begin
                    foreach (step_results[k]) expected_results.push_back(step_results[k]);
                end
                stim_idx++;
            end

            mode = stim_idx < DIR_ROWS ? IDLE_NONE
                                       : idle_mode_e'(((stim_idx - DIR_ROWS) / 45) % 4);
            case (mode)
                IDLE_SEND: begin
                    gap_pct = 55;
                    stall_pct = 0;
                end
                IDLE_RECV: begin
                    gap_pct = 0;
                    stall_pct = 55;
                end
                IDLE_BOTH: begin
                    gap_pct = 19;
                    stall_pct = 19;
                end
                default: begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
            endcase

            if (!i_valid || take) begin
                if (stim_idx < stim_q.size() && $urandom_range(99) >= gap_pct
                    && !(stim_q[stim_idx].pause && expected_results.size() != 0)) begin
                    i_valid <= 1'b1;
                    i_target_byte <= stim_q[stim_idx].tb;
                    i_is_last <= stim_q[stim_idx].last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= $urandom_range(99) < stall_pct;
        end
    end

    initial begin
        stim_t dir_table [DIR_ROWS];
        dir_table = '{
            known_row(8'hFF, 1'b0, 1, mk_result(8'hFF, PART_PATH, EV_BYTE, 1'b1), '0, '0),
            plain(CH_PLUS, 1'b0, 1'b0),
            known_row(CH_QUERY, 1'b0, 0, '0, '0, '0),
            plain(CH_PCT, 1'b0, 1'b0),
            plain("z", 1'b0, 1'b0),
            plain("Z", 1'b0, 1'b0),
            plain(CH_EQ, 1'b0, 1'b0),
            plain(CH_PLUS, 1'b0, 1'b0),
            plain(CH_EQ, 1'b0, 1'b0),
            plain(CH_AMP, 1'b0, 1'b0),
            plain(CH_AMP, 1'b0, 1'b0),
            plain("a", 1'b0, 1'b0),
            plain(CH_AMP, 1'b0, 1'b0),
            plain(CH_PCT, 1'b0, 1'b0),
            plain("0", 1'b0, 1'b0),
            plain("0", 1'b1, 1'b0),
            known_row(CH_QUERY, 1'b1, 1, mk_result(8'h00, PART_NONE, EV_END, 1'b1), '0, '0),
            plain(CH_QUERY, 1'b0, 1'b0),
            known_row(CH_PCT, 1'b1, 2, mk_result(8'h00, PART_NONE, EV_BAD, 1'b0),
                      mk_result(8'h00, PART_NONE, EV_END, 1'b1), '0),
            plain(CH_QUERY, 1'b0, 1'b0),
            plain(CH_PCT, 1'b0, 1'b0),
            known_row("9", 1'b1, 2, mk_result(8'h00, PART_NONE, EV_BAD, 1'b0),
                      mk_result(8'h00, PART_NONE, EV_END, 1'b1), '0),
            plain(CH_QUERY, 1'b0, 1'b0),
            plain(CH_PCT, 1'b0, 1'b0),
            known_row(CH_AMP, 1'b0, 1, mk_result(8'h00, PART_NONE, EV_BAD, 1'b1), '0, '0),
            known_row(8'h00, 1'b1, 1, mk_result(8'h00, PART_NONE, EV_END, 1'b1), '0, '0)
        };
        foreach (dir_table[i]) stim_q.push_back(dir_table[i]);
        gen_target(1'b1);
        while (stim_q.size() < DIR_ROWS + RAND_ITEMS) gen_target($urandom_range(19) == 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (stim_idx < stim_q.size() || expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("url_query_splitter_decoder: match");
        end else begin
            $display("url_query_splitter_decoder: mismatch");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("url_query_splitter_decoder: mismatch");
        $finish;
    end

endmodule
